// ----- hw/rtl/degc_pkg.sv -----
// Package for the dependency graph block: item types, status codes, sizes.
// No dependencies.
`default_nettype none
package degc_pkg;
   localparam int MAX_STEPS_DEF = 32;
   localparam int MAX_EDGES_DEF = 64;
   localparam int KEY_BITS_DEF  = 32;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_EXISTS    = 3'd2,
      ST_CAPACITY  = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_CYCLE     = 3'd5
   } status_type;

   typedef enum logic {
      FUNC_ADD_STEP = 1'b0,
      FUNC_ADD_EDGE = 1'b1
   } func_type;

   typedef struct packed {
      logic        func;
      logic [31:0] first_key;
      logic [31:0] second_key;
      logic        step_ok;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] step_total;
      logic [6:0] edge_total;
   } rsp_type;
endpackage
`default_nettype wire

// ----- hw/rtl/degc_key_table.sv -----
// Step key memory with a sequential search port.
// Depends on degc_pkg.
`default_nettype none
module degc_key_table #(
   parameter int MAX_STEPS = degc_pkg::MAX_STEPS_DEF,
   parameter int KEY_BITS  = degc_pkg::KEY_BITS_DEF,
   localparam int SW = $clog2(MAX_STEPS)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [SW-1:0]       wr_addr,
   input  wire logic [KEY_BITS-1:0] wr_data,
   input  wire logic [SW-1:0]       rd_addr,
   output logic      [KEY_BITS-1:0] rd_data
);
   logic [KEY_BITS-1:0] mem [MAX_STEPS];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/degc_edge_table.sv -----
// Edge memory: one (from, to) pair of step indices per entry.
// Depends on degc_pkg.
`default_nettype none
module degc_edge_table #(
   parameter int MAX_STEPS = degc_pkg::MAX_STEPS_DEF,
   parameter int MAX_EDGES = degc_pkg::MAX_EDGES_DEF,
   localparam int SW = $clog2(MAX_STEPS),
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [EW-1:0]   wr_addr,
   input  wire logic [2*SW-1:0] wr_data,
   input  wire logic [EW-1:0]   rd_addr,
   output logic      [2*SW-1:0] rd_data
);
   logic [2*SW-1:0] mem [MAX_EDGES];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/degc_walk_stack.sv -----
// Walk stack memory holding step indices for the depth-first search.
// Depends on degc_pkg.
`default_nettype none
module degc_walk_stack #(
   parameter int MAX_STEPS = degc_pkg::MAX_STEPS_DEF,
   localparam int SW = $clog2(MAX_STEPS)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [SW-1:0] wr_addr,
   input  wire logic [SW-1:0] wr_data,
   input  wire logic [SW-1:0] rd_addr,
   output logic      [SW-1:0] rd_data
);
   logic [SW-1:0] mem [MAX_STEPS];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/dag_edge_insert_cycle_check.sv -----
// Top level: dependency graph of keyed steps with cycle rejection.
// Depends on degc_pkg, degc_key_table, degc_edge_table, degc_walk_stack.
//
//  channel | ports                        | handshake
//  request | req_item                     | start & !busy
//  result  | rsp_item, rsp_valid          | strobe, one cycle, no stall
//
// Add step: the key search reads every stored step, then the decision sets the strobe.
// Add edge: key search, then the walk: per popped step a pop, a stack read,
//   a read of every stored edge and a drain, with at most one pop per stored
//   step; the edge memory has a single read port, so edges are read in turn.
// Reset clears counts and control; memories need no clearing.
// The result strobes for one cycle; busy stays high until then.
`default_nettype none
module dag_edge_insert_cycle_check #(
   parameter int MAX_STEPS = degc_pkg::MAX_STEPS_DEF,
   parameter int MAX_EDGES = degc_pkg::MAX_EDGES_DEF,
   parameter int KEY_BITS  = degc_pkg::KEY_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire degc_pkg::req_type req_item,
   output logic                  busy,
   output logic                  rsp_valid,
   output degc_pkg::rsp_type     rsp_item
);
   localparam int SW  = $clog2(MAX_STEPS);
   localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int SCW = $clog2(MAX_STEPS + 1);
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int KB  = (KEY_BITS < 32) ? KEY_BITS : 32;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SRCH  = 7'b0000010,
      S_DEC   = 7'b0000100,
      S_POP   = 7'b0001000,
      S_NODE  = 7'b0010000,
      S_SCAN  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic             func_ff, func_in, ok_ff, ok_in;
   logic [KB-1:0]    k1_ff, k1_in, k2_ff, k2_in;
   logic [SCW-1:0]   nsteps_ff, nsteps_in;
   logic [ECW-1:0]   nedges_ff, nedges_in;
   logic [SCW-1:0]   sidx_ff, sidx_in;
   logic             f1_ff, f1_in, f2_ff, f2_in, rdv_ff, rdv_in;
   logic [SW-1:0]    a_ff, a_in, b_ff, b_in, node_ff, node_in;
   logic [SCW-1:0]   depth_ff, depth_in;
   logic [ECW-1:0]   eidx_ff, eidx_in;
   logic             erv_ff, erv_in;
   logic [MAX_STEPS-1:0] vis_ff, vis_in;
   logic [2:0]       st_ff, st_in;
   logic             rv_ff, rv_in;

   logic             kwr, ewr, swr;
   logic [SW-1:0]    kwa, krd_a, swa, srd_a;
   logic [KB-1:0]    krd;
   logic [EW-1:0]    ewa, erd_a;
   logic [2*SW-1:0]  erd;
   logic [SW-1:0]    swd, srd;
   logic [SW-1:0]    e_from, e_to;

   degc_key_table #(.MAX_STEPS(MAX_STEPS), .KEY_BITS(KB)) u_keys (
      .clock(clock), .wr_en(kwr), .wr_addr(kwa), .wr_data(k1_ff),
      .rd_addr(krd_a), .rd_data(krd));
   degc_edge_table #(.MAX_STEPS(MAX_STEPS), .MAX_EDGES(MAX_EDGES)) u_edges (
      .clock(clock), .wr_en(ewr), .wr_addr(ewa), .wr_data({a_ff, b_ff}),
      .rd_addr(erd_a), .rd_data(erd));
   degc_walk_stack #(.MAX_STEPS(MAX_STEPS)) u_stack (
      .clock(clock), .wr_en(swr), .wr_addr(swa), .wr_data(swd),
      .rd_addr(srd_a), .rd_data(srd));

   assign e_from = erd[2*SW-1:SW];
   assign e_to   = erd[SW-1:0];

   always_comb begin
      state_in = state_ff;
      func_in = func_ff; ok_in = ok_ff; k1_in = k1_ff; k2_in = k2_ff;
      nsteps_in = nsteps_ff; nedges_in = nedges_ff;
      sidx_in = sidx_ff; f1_in = f1_ff; f2_in = f2_ff; rdv_in = 1'b0;
      a_in = a_ff; b_in = b_ff; node_in = node_ff; depth_in = depth_ff;
      eidx_in = eidx_ff; erv_in = 1'b0; vis_in = vis_ff;
      st_in = st_ff; rv_in = 1'b0;
      kwr = 1'b0; kwa = nsteps_ff[SW-1:0];
      krd_a = sidx_ff[SW-1:0];
      ewr = 1'b0; ewa = nedges_ff[EW-1:0]; erd_a = eidx_ff[EW-1:0];
      swr = 1'b0; swa = depth_ff[SW-1:0]; swd = b_ff;
      srd_a = depth_ff[SW-1:0] - SW'(1);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in = req_item.func;
               ok_in = req_item.step_ok;
               k1_in = req_item.first_key[KB-1:0];
               k2_in = req_item.second_key[KB-1:0];
               sidx_in = '0; f1_in = 1'b0; f2_in = 1'b0;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (rdv_ff) begin
               if (krd == k1_ff && !f1_ff) begin
                  f1_in = 1'b1; a_in = SW'(sidx_ff - SCW'(1));
               end
               if (krd == k2_ff && !f2_ff) begin
                  f2_in = 1'b1; b_in = SW'(sidx_ff - SCW'(1));
               end
            end
            if (sidx_ff < nsteps_ff) begin
               rdv_in = 1'b1; sidx_in = sidx_ff + SCW'(1);
            end else if (!rdv_ff) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_DONE; rv_in = 1'b1;
            if (func_ff == degc_pkg::FUNC_ADD_STEP) begin
               if (!ok_ff) st_in = degc_pkg::ST_INVALID;
               else if (f1_ff) st_in = degc_pkg::ST_EXISTS;
               else if (nsteps_ff >= SCW'(MAX_STEPS)) st_in = degc_pkg::ST_CAPACITY;
               else begin
                  kwr = 1'b1; nsteps_in = nsteps_ff + SCW'(1);
                  st_in = degc_pkg::ST_OK;
               end
            end else begin
               if (k1_ff == k2_ff) st_in = degc_pkg::ST_INVALID;
               else if (!f1_ff || !f2_ff) st_in = degc_pkg::ST_NOT_FOUND;
               else if (nedges_ff >= ECW'(MAX_EDGES)) st_in = degc_pkg::ST_CAPACITY;
               else begin
                  rv_in = 1'b0;
                  ewr = 1'b1; nedges_in = nedges_ff + ECW'(1);
                  vis_in = '0; vis_in[b_ff] = 1'b1;
                  swr = 1'b1; swa = '0; swd = b_ff;
                  depth_in = SCW'(1);
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            if (depth_ff == '0) begin
               st_in = degc_pkg::ST_OK; rv_in = 1'b1; state_in = S_DONE;
            end else begin
               depth_in = depth_ff - SCW'(1);
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            node_in = srd;
            if (srd == a_ff) begin
               nedges_in = nedges_ff - ECW'(1);
               st_in = degc_pkg::ST_CYCLE; rv_in = 1'b1; state_in = S_DONE;
            end else begin
               eidx_in = '0; state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (erv_ff && e_from == node_ff && !vis_ff[e_to]) begin
               vis_in[e_to] = 1'b1;
               swr = 1'b1; swd = e_to; depth_in = depth_ff + SCW'(1);
            end
            if (eidx_ff < nedges_ff) begin
               erv_in = 1'b1; eidx_in = eidx_ff + ECW'(1);
            end else if (!erv_ff) begin
               state_in = S_POP;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; nsteps_ff <= '0; nedges_ff <= '0;
         rv_ff <= 1'b0; rdv_ff <= 1'b0; erv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; nsteps_ff <= nsteps_in; nedges_ff <= nedges_in;
         rv_ff <= rv_in; rdv_ff <= rdv_in; erv_ff <= erv_in;
      end
      func_ff <= func_in; ok_ff <= ok_in; k1_ff <= k1_in; k2_ff <= k2_in;
      sidx_ff <= sidx_in; f1_ff <= f1_in; f2_ff <= f2_in;
      a_ff <= a_in; b_ff <= b_in; node_ff <= node_in; depth_ff <= depth_in;
      eidx_ff <= eidx_in; vis_ff <= vis_in; st_ff <= st_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_item.status = st_ff;
   assign rsp_item.step_total = 6'(nsteps_ff);
   assign rsp_item.edge_total = 7'(nedges_ff);
endmodule
`default_nettype wire

// ----- hw/rtl/degc_checker.sv -----
// Port-level checker for the dependency graph block, bound to the top level.
// Depends on degc_pkg and dag_edge_insert_cycle_check.
`default_nettype none
module degc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire degc_pkg::rsp_type rsp_item
);
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("no busy after start");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside item");
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe too long");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.status <= 3'd5) else $error("bad status");
endmodule

bind dag_edge_insert_cycle_check degc_checker u_degc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_item(rsp_item));
`default_nettype wire
